>>> design/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package q2e_pkg;

  localparam int QW      = 16;  // quaternion component width
  localparam int PW      = 32;  // product width
  localparam int TW      = 34;  // sine / cosine term width (30 fraction bits)
  localparam int SPW     = 32;  // clamped pitch sine width
  localparam int RW      = 64;  // isqrt working width
  localparam int ROOTW   = 31;  // isqrt result width, root <= 2^30
  localparam int CW      = 38;  // CORDIC x/y width
  localparam int ZW      = 20;  // CORDIC angle width, 16 fraction bits
  localparam int ITER    = 16;  // CORDIC iterations
  localparam int ISQ_STG = 16;  // isqrt stages, two root bits each

  localparam logic signed [ZW-1:0] HALF_PI   = 20'sd102944;
  localparam logic signed [ZW-1:0] OUT_PI    = 20'sd25736;
  localparam logic signed [ZW-1:0] OUT_HALF  = 20'sd12868;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] root;
  } isq_t;

  // atan(2^-i), 16 fraction bits, rounded
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  // one restoring square-root step
  function automatic isq_t isq_step(input isq_t s, input logic [RW-1:0] bitv);
    isq_t o;
    logic [RW-1:0] trial;
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> design/q2e_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined floor square root, two result bits per stage.
module q2e_isqrt (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [q2e_pkg::RW-1:0]     radicand,
  output logic      [q2e_pkg::ROOTW-1:0]  root
);

  q2e_pkg::isq_t stg [q2e_pkg::ISQ_STG];

  for (genvar k = 0; k < q2e_pkg::ISQ_STG; k++) begin : g_stg
    q2e_pkg::isq_t s_in, s_mid, s_out;
    always_comb begin
      if (k == 0) begin
        s_in.rem  = radicand;
        s_in.root = '0;
      end else begin
        s_in = stg[(k == 0) ? 0 : k-1];
      end
      s_mid = q2e_pkg::isq_step(s_in,
                (q2e_pkg::RW)'(64'd1 << (62 - 4*k)));
      s_out = q2e_pkg::isq_step(s_mid,
                (q2e_pkg::RW)'(64'd1 << (60 - 4*k)));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= s_out;
      end
    end
  end

  assign root = stg[q2e_pkg::ISQ_STG-1].root[q2e_pkg::ROOTW-1:0];

endmodule

`default_nettype wire

>>> design/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

// Vectoring CORDIC atan2(y, x): one quadrant-fix stage, then one stage
// per iteration.
module q2e_cordic (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [q2e_pkg::CW-1:0]  x_in,
  input  wire logic signed [q2e_pkg::CW-1:0]  y_in,
  output logic      signed [q2e_pkg::ZW-1:0]  angle
);

  logic signed [q2e_pkg::CW-1:0] xs [q2e_pkg::ITER+1];
  logic signed [q2e_pkg::CW-1:0] ys [q2e_pkg::ITER+1];
  logic signed [q2e_pkg::ZW-1:0] zs [q2e_pkg::ITER+1];
  logic                          zero [q2e_pkg::ITER+1];

  logic signed [q2e_pkg::CW-1:0] x0_next, y0_next;
  logic signed [q2e_pkg::ZW-1:0] z0_next;

  always_comb begin
    x0_next = x_in;
    y0_next = y_in;
    z0_next = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x0_next = y_in;
        y0_next = -x_in;
        z0_next = q2e_pkg::HALF_PI;
      end else begin
        x0_next = -y_in;
        y0_next = x_in;
        z0_next = -q2e_pkg::HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= x0_next;
      ys[0]   <= y0_next;
      zs[0]   <= z0_next;
      zero[0] <= (x_in == 0) && (y_in == 0);
    end
  end

  for (genvar i = 0; i < q2e_pkg::ITER; i++) begin : g_it
    logic signed [q2e_pkg::CW-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + q2e_pkg::atan_tab(i);
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - q2e_pkg::atan_tab(i);
        end
      end
    end
  end

  assign angle = zero[q2e_pkg::ITER] ? '0 : zs[q2e_pkg::ITER];

endmodule

`default_nettype wire

>>> design/quaternion_to_euler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata[63:0]  quaternion request
// m_*      | out | m_tvalid/m_tready  | m_tdata[47:0]  Euler angles
//
// There are 37 register stages and the accepting edge loads the first one:
// 3 stages of products and sums, 16 square-root stages, 17 CORDIC stages,
// 1 output. One request per cycle is taken while the output is not stalled;
// the depth is set by the square-root and CORDIC pipelines. A single enable
// stalls every stage while the output register holds an untaken result, so
// nothing is lost or repeated.
// rst clears the valid bits only.
module quaternion_to_euler_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // roll_angle, pitch_angle, yaw_angle,
                                      // pitch_saturated
);

  localparam int LAT  = 3 + q2e_pkg::ISQ_STG + q2e_pkg::ITER + 1;  // to cordic out
  localparam int DLY  = 1 + q2e_pkg::ISQ_STG;   // s2 -> isqrt out
  localparam int SDLY = DLY + q2e_pkg::ITER + 1; // s2 -> cordic out

  localparam logic signed [q2e_pkg::TW-1:0] SIN_ONE = 34'sd1073741824;
  localparam logic [q2e_pkg::RW-1:0]        SQ_ONE  = 64'd1 << 60;

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // Stage 1: products
  logic signed [q2e_pkg::QW-1:0] qx, qy, qz, qw;
  assign qx = s_tdata[15:0];
  assign qy = s_tdata[31:16];
  assign qz = s_tdata[47:32];
  assign qw = s_tdata[63:48];

  logic signed [q2e_pkg::PW-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  // Stage 2: sine/cosine terms, pitch sine clamp
  logic signed [q2e_pkg::PW:0]   t_sr, t_cr, t_sp, t_sy, t_cy;
  logic signed [q2e_pkg::TW-1:0] sp_raw;
  logic signed [q2e_pkg::SPW-1:0] sp_next;
  logic                          sat_next;

  always_comb begin
    t_sr   = 33'(p_wx) + 33'(p_yz);
    t_cr   = 33'(p_xx) + 33'(p_yy);
    t_sp   = 33'(p_wy) - 33'(p_zx);
    t_sy   = 33'(p_wz) + 33'(p_xy);
    t_cy   = 33'(p_yy) + 33'(p_zz);
    sp_raw = {t_sp, 1'b0};
    sat_next = 1'b0;
    if (sp_raw > SIN_ONE) begin
      sp_next  = 32'sd1073741824;
      sat_next = 1'b1;
    end else if (sp_raw < -SIN_ONE) begin
      sp_next  = -32'sd1073741824;
      sat_next = 1'b1;
    end else begin
      sp_next  = sp_raw[q2e_pkg::SPW-1:0];
    end
  end

  logic signed [q2e_pkg::TW-1:0]  sr, cr, sy, cy;
  logic signed [q2e_pkg::SPW-1:0] sp;
  logic                           sat;

  always_ff @(posedge clk) begin
    if (ce) begin
      sr  <= {t_sr, 1'b0};
      cr  <= SIN_ONE - $signed({t_cr, 1'b0});
      sy  <= {t_sy, 1'b0};
      cy  <= SIN_ONE - $signed({t_cy, 1'b0});
      sp  <= sp_next;
      sat <= sat_next;
    end
  end

  // Stage 3: radicand 1 - s^2
  logic signed [63:0]         sp_sq;
  logic [q2e_pkg::RW-1:0]     radicand;
  assign sp_sq = sp * sp;

  always_ff @(posedge clk) begin
    if (ce) begin
      radicand <= SQ_ONE - sp_sq;
    end
  end

  logic [q2e_pkg::ROOTW-1:0] root;

  q2e_isqrt u_isqrt (
    .clk      (clk),
    .en       (ce),
    .radicand (radicand),
    .root     (root)
  );

  // Operand delay lines, aligned with the square root output; the saturation flag runs on to the CORDIC output
  logic signed [q2e_pkg::TW-1:0]  sr_d [DLY];
  logic signed [q2e_pkg::TW-1:0]  cr_d [DLY];
  logic signed [q2e_pkg::TW-1:0]  sy_d [DLY];
  logic signed [q2e_pkg::TW-1:0]  cy_d [DLY];
  logic signed [q2e_pkg::SPW-1:0] sp_d [DLY];
  logic                           sat_d [SDLY];

  always_ff @(posedge clk) begin
    if (ce) begin
      sr_d[0]  <= sr;
      cr_d[0]  <= cr;
      sy_d[0]  <= sy;
      cy_d[0]  <= cy;
      sp_d[0]  <= sp;
      sat_d[0] <= sat;
      for (int k = 1; k < DLY; k++) begin
        sr_d[k] <= sr_d[k-1];
        cr_d[k] <= cr_d[k-1];
        sy_d[k] <= sy_d[k-1];
        cy_d[k] <= cy_d[k-1];
        sp_d[k] <= sp_d[k-1];
      end
      for (int k = 1; k < SDLY; k++) begin
        sat_d[k] <= sat_d[k-1];
      end
    end
  end

  logic signed [q2e_pkg::ZW-1:0] roll_z, pitch_z, yaw_z;

  q2e_cordic u_roll (
    .clk   (clk),
    .en    (ce),
    .x_in  (q2e_pkg::CW'(cr_d[DLY-1])),
    .y_in  (q2e_pkg::CW'(sr_d[DLY-1])),
    .angle (roll_z)
  );

  q2e_cordic u_pitch (
    .clk   (clk),
    .en    (ce),
    .x_in  ($signed({{(q2e_pkg::CW-q2e_pkg::ROOTW){1'b0}}, root})),
    .y_in  (q2e_pkg::CW'(sp_d[DLY-1])),
    .angle (pitch_z)
  );

  q2e_cordic u_yaw (
    .clk   (clk),
    .en    (ce),
    .x_in  (q2e_pkg::CW'(cy_d[DLY-1])),
    .y_in  (q2e_pkg::CW'(sy_d[DLY-1])),
    .angle (yaw_z)
  );

  // Round half up to Q3.13 and saturate
  function automatic logic signed [q2e_pkg::ZW-1:0] to_q13(
    input logic signed [q2e_pkg::ZW-1:0] a,
    input logic signed [q2e_pkg::ZW-1:0] lim
  );
    logic signed [q2e_pkg::ZW-1:0] r;
    r = (a + 20'sd4) >>> 3;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [q2e_pkg::ZW-1:0] roll_r, pitch_r, yaw_r;
  assign roll_r  = to_q13(roll_z, q2e_pkg::OUT_PI);
  assign pitch_r = to_q13(pitch_z, q2e_pkg::OUT_HALF);
  assign yaw_r   = to_q13(yaw_z, q2e_pkg::OUT_PI);

  // Valid bits
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      vld      <= {vld[LAT-2:0], s_tvalid};
      m_tvalid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {sat_d[SDLY-1], yaw_r[15:0], pitch_r[14:0], roll_r[15:0]};
    end
  end

endmodule

`default_nettype wire

>>> sim/q2e_checker.sv
`timescale 1ns / 1ps

module q2e_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               sat;
  } euler_t;

  euler_t angle_q[$];

  assign pending = angle_q.size();

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, 16 fraction bits
  function automatic longint vec_angle(longint ys, longint xc);
    longint atans [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
    longint x, y, z, t, dx, dy;
    x = xc; y = ys; z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atans[i];
      end else begin
        x -= dx; y += dy; z -= atans[i];
      end
    end
    return z;
  endfunction

  function automatic longint to_q13(longint a, longint lim);
    longint r;
    r = floor_shr(a + 4, 3);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_angles(logic [63:0] d);
    longint qx, qy, qz, qw, s, c, one;
    euler_t e;
    one = longint'(1) << 30;
    qx = longint'($signed(d[15:0]));
    qy = longint'($signed(d[31:16]));
    qz = longint'($signed(d[47:32]));
    qw = longint'($signed(d[63:48]));
    e.sat = 1'b0;
    s = 2 * (qw * qx + qy * qz);
    c = one - 2 * (qx * qx + qy * qy);
    e.roll = 16'(to_q13(vec_angle(s, c), 25736));
    s = 2 * (qw * qy - qz * qx);
    if (s > one) begin s = one; e.sat = 1'b1; end
    if (s < -one) begin s = -one; e.sat = 1'b1; end
    c = int_sqrt(one * one - s * s);
    e.pitch = 15'(to_q13(vec_angle(s, c), 12868));
    s = 2 * (qw * qz + qx * qy);
    c = one - 2 * (qy * qy + qz * qz);
    e.yaw = 16'(to_q13(vec_angle(s, c), 25736));
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    euler_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) angle_q = {angle_q, predict_angles(s_tdata)};
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[30:16], m_tdata[46:31], m_tdata[47]};
        if (angle_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = angle_q.pop_front();
          if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
          if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
          if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
          if (got.sat !== want.sat) report_mismatch("sat", got.sat, want.sat);
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the quaternion to Euler core. The checker
// predicts each request's angles and compares them in order.
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // roll, pitch, yaw, pitch_saturated
  int          fail_count, pending;
  int          send_idle = 0, recv_idle = 0;  // idle percentages

  always #2 clk = ~clk;

  quaternion_to_euler_core dut (.*);

  q2e_checker chk (.*);

  // receiver stall pattern
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  task automatic send_quat(logic [15:0] x, y, z, w);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly scaled-down random components, some raw noise
  task automatic send_random;
    logic [15:0] c[4];
    int sh;
    sh = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      c[i] = 16'($urandom);
      if ($urandom_range(3) != 0) c[i] = 16'($signed(c[i]) >>> (1 + sh));
    end
    send_quat(c[0], c[1], c[2], c[3]);
  endtask

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: identity, zero, gimbal-lock, axis turns, extremes
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);  // roll at pi
    send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000);
    send_quat(16'h0000, 16'h5a82, 16'h0000, 16'h5a82);  // pitch +90
    send_quat(16'h0000, 16'ha57e, 16'h0000, 16'h5a82);  // pitch -90
    send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h7fff);  // sine clamps high
    send_quat(16'h0000, 16'h8000, 16'h0000, 16'h7fff);  // sine clamps low
    for (int i = 0; i < 5; i++) send_quat(ext[i], ext[(i+1)%5], ext[(i+2)%5], ext[(i+3)%5]);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_idle = 22; recv_idle = 81;
    repeat (280) send_random();
    send_idle = 81; recv_idle = 22;
    repeat (280) send_random();
    send_idle = 0; recv_idle = 0;
    repeat (280) send_random();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/q2e_pkg.sv
design/q2e_isqrt.sv
design/q2e_cordic.sv
design/quaternion_to_euler_core.sv
sim/q2e_checker.sv
sim/tb.sv
